### rtl/assert_macros.svh
// Assertion helpers for the I2C master byte engine.
// Each macro takes a label, clock, active-low reset and a property body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define I2CM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

`define I2CM_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

`else

`define I2CM_ASSERT(lbl, clk, rstn, prop)

`define I2CM_ASSERT_MSG(lbl, clk, rstn, prop, msg)

`endif

`endif

### rtl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

    // Command codes
    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_START     = 3'd1,
        CMD_STOP      = 3'd2,
        CMD_WRITE     = 3'd3,
        CMD_READ_ACK  = 3'd4,
        CMD_READ_NACK = 3'd5
    } cmd_t;

    // Phase step codes; start and stop use the first three in order
    localparam logic [2:0] STEP_BIT_LOW  = 3'd0;
    localparam logic [2:0] STEP_BIT_HIGH = 3'd1;
    localparam logic [2:0] STEP_ACK_LOW  = 3'd2;
    localparam logic [2:0] STEP_ACK_HIGH = 3'd3;
    localparam logic [2:0] STEP_ACK_END  = 3'd4;

    localparam logic [2:0]  LAST_BIT        = 3'd7;
    localparam logic [15:0] HALF_PERIOD_RST = 16'd500;

    typedef struct packed {
        logic scl;
        logic sda;
    } lines_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } result_t;

    // Bus levels for a given command and phase step
    function automatic lines_t drive_lines(cmd_t c, logic [2:0] s, logic msb, lines_t cur);
        lines_t l;
        l = cur;
        case (c)
            CMD_START:
            begin
                l.scl = (s <= STEP_BIT_HIGH);
                l.sda = (s == STEP_BIT_LOW);
            end
            CMD_STOP:
            begin
                l.scl = (s >= STEP_BIT_HIGH);
                l.sda = (s == STEP_ACK_LOW);
            end
            CMD_WRITE, CMD_READ_ACK, CMD_READ_NACK:
            begin
                if (s <= STEP_BIT_HIGH)
                begin
                    l.scl = s[0];
                    l.sda = (c == CMD_WRITE) ? msb : 1'b1;
                end
                else
                begin
                    l.scl = (s == STEP_ACK_HIGH);
                    l.sda = (c != CMD_READ_ACK);
                end
            end
            default:
            begin
                l = cur;
            end
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

### rtl/i2cm_core.sv
`default_nettype none

`include "assert_macros.svh"

module i2cm_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [15:0]      cfg_wr_data,
    input  wire logic             acc,
    input  wire logic [2:0]       cmd,
    input  wire logic [7:0]       tx_byte,
    input  wire logic             sda_in,
    output i2cm_pkg::result_t     res
);

    i2cm_pkg::cmd_t  active_reg, active_next;
    logic [2:0]      step_reg, step_next;
    logic [2:0]      bit_reg, bit_next;
    logic [7:0]      shift_reg, shift_next;
    logic [15:0]     tick_reg, tick_next;
    i2cm_pkg::lines_t lines_reg, lines_next;
    logic            ack_reg, ack_next;
    logic [7:0]      rx_reg, rx_next;
    logic [15:0]     half_reg;
    logic [15:0]     h;
    logic [16:0]     t;
    logic            fin;
    logic            done_c;

    // Hold the phase length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_reg <= i2cm_pkg::HALF_PERIOD_RST;
        else if (cfg_wr_en)
            half_reg <= cfg_wr_data;
    end

    // Work out one tick of the sequencer
    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        tick_next   = tick_reg;
        lines_next  = lines_reg;
        ack_next    = ack_reg;
        rx_next     = rx_reg;
        fin         = 1'b0;
        done_c      = 1'b0;
        h = (half_reg == 16'd0) ? 16'd1 : half_reg;
        t = {1'b0, tick_reg} + 17'd1;

        if (active_reg == i2cm_pkg::CMD_NONE)
        begin
            if (cmd inside {[i2cm_pkg::CMD_START:i2cm_pkg::CMD_READ_NACK]})
            begin
                active_next = i2cm_pkg::cmd_t'(cmd);
                step_next   = i2cm_pkg::STEP_BIT_LOW;
                bit_next    = 3'd0;
                tick_next   = 16'd0;
                shift_next  = (active_next == i2cm_pkg::CMD_WRITE) ? tx_byte : 8'd0;
                lines_next  = i2cm_pkg::drive_lines(active_next, step_next,
                                                    shift_next[7], lines_reg);
            end
        end
        else if (t >= {1'b0, h})
        begin
            tick_next = 16'd0;
            if (active_reg == i2cm_pkg::CMD_START || active_reg == i2cm_pkg::CMD_STOP)
            begin
                if (step_reg >= i2cm_pkg::STEP_ACK_LOW)
                    fin = 1'b1;
                else
                    step_next = step_reg + 3'd1;
            end
            else
            begin
                case (step_reg)
                    i2cm_pkg::STEP_BIT_LOW:
                    begin
                        step_next = i2cm_pkg::STEP_BIT_HIGH;
                    end
                    i2cm_pkg::STEP_BIT_HIGH:
                    begin
                        if (active_reg == i2cm_pkg::CMD_WRITE)
                            shift_next = {shift_reg[6:0], 1'b0};
                        else
                            shift_next = {shift_reg[6:0], sda_in};
                        if (bit_reg == i2cm_pkg::LAST_BIT)
                        begin
                            if (active_reg != i2cm_pkg::CMD_WRITE)
                                rx_next = shift_next;
                            bit_next  = 3'd0;
                            step_next = i2cm_pkg::STEP_ACK_LOW;
                        end
                        else
                        begin
                            bit_next  = bit_reg + 3'd1;
                            step_next = i2cm_pkg::STEP_BIT_LOW;
                        end
                    end
                    i2cm_pkg::STEP_ACK_LOW:
                    begin
                        step_next = i2cm_pkg::STEP_ACK_HIGH;
                    end
                    i2cm_pkg::STEP_ACK_HIGH:
                    begin
                        if (active_reg == i2cm_pkg::CMD_WRITE)
                            ack_next = sda_in;
                        step_next = i2cm_pkg::STEP_ACK_END;
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end

            if (fin)
            begin
                // release SDA after a read, drop back to idle
                if (active_reg == i2cm_pkg::CMD_READ_ACK ||
                    active_reg == i2cm_pkg::CMD_READ_NACK)
                    lines_next.sda = 1'b1;
                active_next = i2cm_pkg::CMD_NONE;
                step_next   = i2cm_pkg::STEP_BIT_LOW;
                bit_next    = 3'd0;
                done_c      = 1'b1;
            end
            else
            begin
                lines_next = i2cm_pkg::drive_lines(active_reg, step_next,
                                                   shift_next[7], lines_reg);
            end
        end
        else
        begin
            tick_next = t[15:0];
        end
    end

    // Advance state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= i2cm_pkg::CMD_NONE;
            step_reg   <= i2cm_pkg::STEP_BIT_LOW;
            bit_reg    <= 3'd0;
            shift_reg  <= 8'd0;
            tick_reg   <= 16'd0;
            lines_reg  <= '{scl: 1'b1, sda: 1'b1};
            ack_reg    <= 1'b0;
            rx_reg     <= 8'd0;
        end
        else if (acc)
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            tick_reg   <= tick_next;
            lines_reg  <= lines_next;
            ack_reg    <= ack_next;
            rx_reg     <= rx_next;
        end
    end

    // Result word for this tick
    assign res.scl  = lines_next.scl;
    assign res.sda  = lines_next.sda;
    assign res.busy = (active_next != i2cm_pkg::CMD_NONE);
    assign res.done = done_c;
    assign res.rx   = rx_next;
    assign res.ack  = ack_next;

    `I2CM_ASSERT(a_done_goes_idle, clk, rst_n,
        (acc && done_c) |=> (active_reg == i2cm_pkg::CMD_NONE))
    `I2CM_ASSERT(a_idle_clean, clk, rst_n,
        (active_reg == i2cm_pkg::CMD_NONE) |->
            (step_reg == i2cm_pkg::STEP_BIT_LOW && bit_reg == 3'd0))
    `I2CM_ASSERT_MSG(a_cond_steps, clk, rst_n,
        (active_reg == i2cm_pkg::CMD_START || active_reg == i2cm_pkg::CMD_STOP) |->
            (step_reg <= i2cm_pkg::STEP_ACK_LOW), "start/stop step out of range")
    `I2CM_ASSERT(a_byte_steps, clk, rst_n,
        (active_reg != i2cm_pkg::CMD_NONE) |-> (step_reg <= i2cm_pkg::STEP_ACK_END))

endmodule

`default_nettype wire

### rtl/i2cm_skid.sv
`default_nettype none

module i2cm_skid (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_stall,
    input  wire i2cm_pkg::result_t push_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output i2cm_pkg::result_t      out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    i2cm_pkg::result_t out_data_reg, out_data_next;
    i2cm_pkg::result_t skid_data_reg, skid_data_next;
    logic              push;
    logic              pop;

    assign push_stall = skid_valid_reg;
    assign push       = push_valid && !skid_valid_reg;
    assign pop        = out_valid_reg && !out_stall;

    // Refill the output register, park a word in the skid slot when held
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### rtl/i2c_master_byte_controller.sv
// I2C master byte engine, one input word per bus timing tick.
// Each result word is registered in the output buffer, or parked in its skid slot while the output is held.
// Throughput: one word per cycle while in_stall is low; the sequencer state updates in a single registered pass.
// A two-entry output buffer keeps input flowing while one result waits to be taken.
// Reset: idle, SCL and SDA released, received byte and ack cleared, phase length 500 ticks.
`default_nettype none

module i2c_master_byte_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [7:0]  tx_byte,
    input  wire logic        sda_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             scl_out,
    output logic             sda_out,
    output logic             busy_res,
    output logic             done_res,
    output logic [7:0]       rx_byte,
    output logic             ack_bit
);

    i2cm_pkg::result_t core_res;
    i2cm_pkg::result_t out_res;
    logic              acc;

    assign acc = in_valid && !in_stall;

    i2cm_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .acc         (acc),
        .cmd         (cmd),
        .tx_byte     (tx_byte),
        .sda_in      (sda_in),
        .res         (core_res)
    );

    i2cm_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_stall (in_stall),
        .push_data  (core_res),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_res)
    );

    // Split the result word onto the output fields
    assign scl_out  = out_res.scl;
    assign sda_out  = out_res.sda;
    assign busy_res = out_res.busy;
    assign done_res = out_res.done;
    assign rx_byte  = out_res.rx;
    assign ack_bit  = out_res.ack;

endmodule

`default_nettype wire
